FILE: hw/rtl/sbbt_pkg.sv
// Shared types and constants for the swept box brush trace block.
// Used by every module of the block; depends on nothing.
package sbbt_pkg;

  localparam int HALF_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W   = 17;
  localparam int DIST_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 2'd2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
  localparam logic signed [DIST_W-1:0] DIST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 48'sh8000_0000_0000;
  localparam logic signed [31:0] Q16_ONE = 32'sd65536;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic mode;
    q16_t vec_x;
    q16_t vec_y;
    q16_t vec_z;
    q16_t move_x;
    q16_t move_y;
    q16_t move_z;
    q16_t plane_offset;
    logic brush_last;
    logic trace_last;
  } sbbt_in_t;

  typedef struct packed {
    logic              hit;
    logic              start_solid;
    logic [FRAC_W-1:0] fraction;
    q16_t              normal_x;
    q16_t              normal_y;
    q16_t              normal_z;
  } sbbt_out_t;

  // Queue entry: the item plus what the front decided about it.
  typedef struct packed {
    logic     is_plane;
    logic     closes_brush;
    logic     ends_trace;
    sbbt_in_t item;
  } sbbt_cmd_t;

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [53:0] x);
    logic signed [DIST_W-1:0] r;
    if (x > 54'(DIST_MAX)) r = DIST_MAX;
    else if (x < -54'(DIST_MAX)) r = -DIST_MAX;
    else r = x[DIST_W-1:0];
    return r;
  endfunction

  function automatic q16_t sat32(input logic signed [32:0] x);
    q16_t r;
    if (x[32] != x[31]) r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = x[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/swept_box_brush_trace.sv
// Top level of the swept box brush trace: configuration registers, the
// front queue and the back engine. Depends on sbbt_pkg, sbbt_front, sbbt_back.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    sbbt_in_t  (segment or plane)
//   out_     output     out_valid / out_stall  sbbt_out_t (trace result)
//   cfg_     input      cfg_we                 cfg_index, cfg_data (half extents)
//
// A segment load stays in S_IDLE; a plane runs S_MUL, S_DIST, S_EVAL,
// S_DIV if the segment crosses it, then S_CLOSE, on the shared 33x33
// multiplier (nine products per plane) and the radix-2 divider (17 steps).
// A plane of a missed brush or after start solid goes straight to S_CLOSE.
// Reset is synchronous and clears the queue, the brush and result state.
// The two-entry queue accepts until full while the back waits on out_stall.
module swept_box_brush_trace import sbbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sbbt_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sbbt_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data
);

  logic [HALF_W-1:0] half_x_r, half_y_r, half_z_r;
  logic      q_valid, q_pop;
  sbbt_cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_x_r <= '0;
      half_y_r <= '0;
      half_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_X: half_x_r <= cfg_data;
        CFG_HALF_Y: half_y_r <= cfg_data;
        CFG_HALF_Z: half_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sbbt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  sbbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .half_x    (half_x_r),
    .half_y    (half_y_r),
    .half_z    (half_z_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/sbbt_front.sv
// Front end of the swept box brush trace: accepts and classifies items
// into a two-entry queue. Depends on sbbt_pkg.
module sbbt_front import sbbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sbbt_in_t  in_data,
  output logic      q_valid,
  output sbbt_cmd_t q_cmd,
  input  logic      q_pop
);

  sbbt_cmd_t  mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push;
  sbbt_cmd_t  cmd;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rd_r];

  always_comb begin
    cmd.item         = in_data;
    cmd.is_plane     = in_data.mode;
    cmd.closes_brush = in_data.mode && (in_data.brush_last || in_data.trace_last);
    cmd.ends_trace   = in_data.mode && in_data.trace_last;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= cmd;
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/sbbt_back.sv
// Back end of the swept box brush trace: plane distances on one shared
// multiplier, crossing fractions on a radix-2 divider, brush and result
// bookkeeping and the output register. Depends on sbbt_pkg.
module sbbt_back import sbbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HALF_W-1:0] half_x,
  input  logic [HALF_W-1:0] half_y,
  input  logic [HALF_W-1:0] half_z,
  input  logic              q_valid,
  input  sbbt_cmd_t         q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sbbt_out_t         out_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIST, S_EVAL, S_DIV, S_CLOSE} state_t;

  state_t    state_r;
  sbbt_cmd_t cmd_r;
  logic [3:0] step_r;
  logic [4:0] div_cnt_r;

  q16_t start_r [3];
  q16_t end_r   [3];
  q16_t enter_n_r [3];
  q16_t deep_n_r  [3];
  q16_t best_n_r  [3];
  logic [FRAC_W-1:0] enter_frac_r, leave_frac_r, best_frac_r;
  logic signed [DIST_W-1:0] deep_r, ds_r, de_r;
  logic got_enter_r, outside_r, missed_r, res_hit_r, res_solid_r;

  logic signed [65:0] prod_r;
  logic signed [51:0] acc_s_r, acc_e_r, acc_h_r;
  logic [49:0]        rem_r;
  logic [48:0]        den_r;
  logic [FRAC_W-1:0]  quo_r;
  logic               dir_enter_r;

  logic              out_valid_r;
  sbbt_out_t         out_data_r;

  q16_t nrm [3];
  logic signed [32:0] mul_a, mul_b;
  logic signed [49:0] pfl;
  logic signed [53:0] dexp, diff_s, diff_e;
  logic [49:0] trial;
  logic        take;
  logic        out_free;
  logic        brush_clr, res_clr;
  logic        c_hit, c_solid;
  logic [FRAC_W-1:0] c_frac;
  q16_t        c_n [3];
  logic signed [48:0] den_w;

  assign nrm[0] = cmd_r.item.vec_x;
  assign nrm[1] = cmd_r.item.vec_y;
  assign nrm[2] = cmd_r.item.vec_z;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operand select for the nine products of one plane.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd0: begin mul_a = {nrm[0][31], nrm[0]}; mul_b = {start_r[0][31], start_r[0]}; end
      4'd1: begin mul_a = {nrm[1][31], nrm[1]}; mul_b = {start_r[1][31], start_r[1]}; end
      4'd2: begin mul_a = {nrm[2][31], nrm[2]}; mul_b = {start_r[2][31], start_r[2]}; end
      4'd3: begin mul_a = {nrm[0][31], nrm[0]}; mul_b = {end_r[0][31], end_r[0]}; end
      4'd4: begin mul_a = {nrm[1][31], nrm[1]}; mul_b = {end_r[1][31], end_r[1]}; end
      4'd5: begin mul_a = {nrm[2][31], nrm[2]}; mul_b = {end_r[2][31], end_r[2]}; end
      4'd6: begin
        mul_a = {2'b00, half_x};
        mul_b = nrm[0][31] ? -{nrm[0][31], nrm[0]} : {nrm[0][31], nrm[0]};
      end
      4'd7: begin
        mul_a = {2'b00, half_y};
        mul_b = nrm[1][31] ? -{nrm[1][31], nrm[1]} : {nrm[1][31], nrm[1]};
      end
      4'd8: begin
        mul_a = {2'b00, half_z};
        mul_b = nrm[2][31] ? -{nrm[2][31], nrm[2]} : {nrm[2][31], nrm[2]};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Dropping the low 16 bits of a two's complement product floors it.
  assign pfl  = prod_r[65:16];
  assign dexp = {{22{cmd_r.item.plane_offset[31]}}, cmd_r.item.plane_offset}
              + {{2{acc_h_r[51]}}, acc_h_r};
  assign diff_s = {{2{acc_s_r[51]}}, acc_s_r} - dexp;
  assign diff_e = {{2{acc_e_r[51]}}, acc_e_r} - dexp;

  assign trial = (div_cnt_r == 5'd0) ? rem_r : {rem_r[48:0], 1'b0};
  assign take  = (trial >= {1'b0, den_r});
  assign den_w = (ds_r > 48'sd0) ? ({ds_r[47], ds_r} - {de_r[47], de_r})
                                 : ({de_r[47], de_r} - {ds_r[47], ds_r});

  // Brush close: what the result becomes once the current brush ends.
  always_comb begin
    c_hit   = res_hit_r;
    c_solid = res_solid_r;
    c_frac  = best_frac_r;
    c_n     = best_n_r;
    if (!missed_r && !res_solid_r) begin
      if (!outside_r) begin
        c_hit   = 1'b1;
        c_solid = 1'b1;
        c_frac  = '0;
        c_n     = deep_n_r;
      end else if (got_enter_r && enter_frac_r <= leave_frac_r &&
                   enter_frac_r < best_frac_r) begin
        c_hit  = 1'b1;
        c_frac = enter_frac_r;
        c_n    = enter_n_r;
      end
    end
  end

  always_comb begin
    brush_clr = 1'b0;
    res_clr   = 1'b0;
    if (state_r == S_IDLE && q_valid && !q_cmd.is_plane) begin
      brush_clr = 1'b1;
      res_clr   = 1'b1;
    end else if (state_r == S_CLOSE && (!cmd_r.ends_trace || out_free)) begin
      brush_clr = cmd_r.closes_brush;
      res_clr   = cmd_r.ends_trace;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      enter_frac_r <= '0;
      leave_frac_r <= FRAC_ONE;
      enter_n_r    <= '{32'sd0, 32'sd0, Q16_ONE};
      deep_r       <= DIST_MIN;
      deep_n_r     <= '{32'sd0, 32'sd0, Q16_ONE};
      got_enter_r  <= 1'b0;
      outside_r    <= 1'b0;
      missed_r     <= 1'b0;
      best_frac_r  <= FRAC_ONE;
      best_n_r     <= '{32'sd0, 32'sd0, 32'sd0};
      res_hit_r    <= 1'b0;
      res_solid_r  <= 1'b0;
    end else begin
      if (state_r == S_CLOSE && cmd_r.ends_trace && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            if (!q_cmd.is_plane) begin
              start_r[0] <= q_cmd.item.vec_x;
              start_r[1] <= q_cmd.item.vec_y;
              start_r[2] <= q_cmd.item.vec_z;
              end_r[0] <= sat32({q_cmd.item.vec_x[31], q_cmd.item.vec_x}
                              + {q_cmd.item.move_x[31], q_cmd.item.move_x});
              end_r[1] <= sat32({q_cmd.item.vec_y[31], q_cmd.item.vec_y}
                              + {q_cmd.item.move_y[31], q_cmd.item.move_y});
              end_r[2] <= sat32({q_cmd.item.vec_z[31], q_cmd.item.vec_z}
                              + {q_cmd.item.move_z[31], q_cmd.item.move_z});
            end else if (missed_r || res_solid_r) begin
              state_r <= S_CLOSE;
            end else begin
              step_r  <= '0;
              acc_s_r <= '0;
              acc_e_r <= '0;
              acc_h_r <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= mul_a * mul_b;
          step_r <= step_r + 4'd1;
          if (step_r >= 4'd1 && step_r <= 4'd3) acc_s_r <= acc_s_r + {{2{pfl[49]}}, pfl};
          if (step_r >= 4'd4 && step_r <= 4'd6) acc_e_r <= acc_e_r + {{2{pfl[49]}}, pfl};
          if (step_r >= 4'd7) acc_h_r <= acc_h_r + {{2{pfl[49]}}, pfl};
          if (step_r == 4'd9) state_r <= S_DIST;
        end
        S_DIST: begin
          ds_r    <= sat_dist(diff_s);
          de_r    <= sat_dist(diff_e);
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (ds_r > deep_r) begin
            deep_r   <= ds_r;
            deep_n_r <= nrm;
          end
          if (ds_r > 48'sd0) outside_r <= 1'b1;
          state_r <= S_CLOSE;
          if (ds_r > 48'sd0 && de_r > 48'sd0) begin
            missed_r <= 1'b1;
          end else if (ds_r > 48'sd0 || de_r > 48'sd0) begin
            rem_r       <= {2'b00, ((ds_r > 48'sd0) ? ds_r : -ds_r)};
            den_r       <= den_w[48:0];
            dir_enter_r <= (ds_r > 48'sd0);
            div_cnt_r   <= '0;
            quo_r       <= '0;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r     <= take ? (trial - {1'b0, den_r}) : trial;
          quo_r     <= {quo_r[FRAC_W-2:0], take};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd16) begin
            state_r <= S_CLOSE;
            if (dir_enter_r) begin
              if ({quo_r[FRAC_W-2:0], take} > enter_frac_r) begin
                enter_frac_r <= {quo_r[FRAC_W-2:0], take};
                enter_n_r    <= nrm;
                got_enter_r  <= 1'b1;
              end
            end else if ({quo_r[FRAC_W-2:0], take} < leave_frac_r) begin
              leave_frac_r <= {quo_r[FRAC_W-2:0], take};
            end
          end
        end
        S_CLOSE: begin
          if (!cmd_r.ends_trace || out_free) begin
            state_r <= S_IDLE;
            if (cmd_r.closes_brush && !cmd_r.ends_trace) begin
              res_hit_r   <= c_hit;
              res_solid_r <= c_solid;
              best_frac_r <= c_frac;
              best_n_r    <= c_n;
            end
            if (cmd_r.ends_trace) begin
              out_data_r.hit         <= c_hit;
              out_data_r.start_solid <= c_solid;
              out_data_r.fraction    <= c_frac;
              out_data_r.normal_x    <= c_n[0];
              out_data_r.normal_y    <= c_n[1];
              out_data_r.normal_z    <= c_n[2];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Brush and result clears; the cycles that clear them write them nowhere else.
      if (brush_clr) begin
        enter_frac_r <= '0;
        leave_frac_r <= FRAC_ONE;
        enter_n_r    <= '{32'sd0, 32'sd0, Q16_ONE};
        deep_r       <= DIST_MIN;
        deep_n_r     <= '{32'sd0, 32'sd0, Q16_ONE};
        got_enter_r  <= 1'b0;
        outside_r    <= 1'b0;
        missed_r     <= 1'b0;
      end
      if (res_clr) begin
        best_frac_r <= FRAC_ONE;
        best_n_r    <= '{32'sd0, 32'sd0, 32'sd0};
        res_hit_r   <= 1'b0;
        res_solid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/sbbt_checker.sv
// Port-level checks for the swept box brush trace, bound to the top level.
// Depends on sbbt_pkg and swept_box_brush_trace.
module sbbt_props import sbbt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input sbbt_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_solid_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_solid |-> out_data.hit && out_data.fraction == '0)
    else $error("start solid result without hit at fraction zero");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.fraction == FRAC_ONE &&
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("result without hit has wrong fields");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fraction <= FRAC_ONE)
    else $error("fraction beyond the whole move");

endmodule

bind swept_box_brush_trace sbbt_props u_sbbt_props (.*);
